/* rtl/rhsv_pkg.sv */
// rhsv_pkg: shared constants, codes and request types for the rgb to hsv converter
// no dependencies
`default_nettype none

package rhsv_pkg;

    localparam int HUE_FRACTION_BITS = 6;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int SAT_SCALE = 255;

    // one hue sector is 60 degrees in fixed point
    localparam int SECTOR_W   = 6 + HUE_FRACTION_BITS;
    localparam int HUE_SECTOR = 60 << HUE_FRACTION_BITS;

    // quotient must hold both a full sector and an 8-bit saturation
    localparam int QUO_W = (SECTOR_W > CHAN_W) ? SECTOR_W : CHAN_W;
    localparam int NUM_W = QUO_W + CHAN_W;

    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    // wide enough for six sectors before the wrap to the output width
    localparam int SUM_W = SECTOR_W + 3;

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } t_sector;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [CHAN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             rem_nz;
    } t_div_rsp;

    typedef struct packed {
        t_sector           sector;
        logic              neg;
        logic              grey;
        logic              black;
        logic [CHAN_W-1:0] vmax;
    } t_side;

endpackage

`default_nettype wire

/* rtl/rgb_to_hsv_convert_top.sv */
// rgb_to_hsv_convert_top: rgb pixel in, hue / saturation / value out, fully pipelined
// depends on rhsv_pkg, rhsv_prep, rhsv_div
//
// usage:
//   input channel i_valid / o_stall carries one rgb pixel per request
//   (i_red, i_green, i_blue); output channel o_valid / i_stall carries
//   o_hue (1/64 degree at the default fraction), o_saturation and o_brightness.
//   a request is taken at a clock edge with valid high and stall low.
//   the path has 3 + DIV_STAGES register stages: two prep stages, six
//   divider stages at two quotient bits each at the default fraction
//   width, and one output register. throughput is one pixel per cycle
//   while not stalled; the divider depth sets the latency, not the rate.
//   when the output register holds a result and i_stall is high the whole
//   pipeline freezes and o_stall goes high; nothing is dropped or repeated.
//   bubbles are not squeezed out while stalled.
//   reset (synchronous, i_rst_n low) clears all valid bits; payload
//   registers keep whatever they hold. no configuration, no state between pixels.
`default_nettype none

module rgb_to_hsv_convert_top
    import rhsv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CHAN_W-1:0] i_red,
    input  wire logic [CHAN_W-1:0] i_green,
    input  wire logic [CHAN_W-1:0] i_blue,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [HUE_W-1:0]       o_hue,
    output logic [CHAN_W-1:0]      o_saturation,
    output logic [CHAN_W-1:0]      o_brightness
);

    logic     en;
    logic     prep_valid;
    t_side    prep_side;
    t_div_req hue_req;
    t_div_req sat_req;
    t_div_rsp hue_rsp;
    t_div_rsp sat_rsp;

    logic     r_vld  [DIV_STAGES];
    t_side    r_side [DIV_STAGES];

    logic              r_out_valid;
    logic [HUE_W-1:0]  r_hue;
    logic [CHAN_W-1:0] r_sat;
    logic [CHAN_W-1:0] r_bright;

    t_side             last_side;
    logic [SUM_W-1:0]  n_base;
    logic [SUM_W-1:0]  n_ceil;
    logic [SUM_W-1:0]  n_sum;
    logic [HUE_W-1:0]  n_hue;
    logic [CHAN_W-1:0] n_sat;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    rhsv_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_valid   (prep_valid),
        .o_side    (prep_side),
        .o_hue_req (hue_req),
        .o_sat_req (sat_req)
    );

    rhsv_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (hue_req),
        .o_rsp (hue_rsp)
    );

    rhsv_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (sat_req),
        .o_rsp (sat_rsp)
    );

    // sideband and valid follow the divider stages
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= (s == 0) ? prep_valid : r_vld[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[s] <= (s == 0) ? prep_side : r_side[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign last_side = r_side[DIV_STAGES-1];

    // negative differences use floor, i.e. base minus the rounded-up quotient
    always_comb begin
        case (last_side.sector)
            SEC_RED:   n_base = last_side.neg ? SUM_W'(6 * HUE_SECTOR) : '0;
            SEC_GREEN: n_base = SUM_W'(2 * HUE_SECTOR);
            SEC_BLUE:  n_base = SUM_W'(4 * HUE_SECTOR);
            default:   n_base = '0;
        endcase
        n_ceil = SUM_W'(hue_rsp.quo) + SUM_W'(hue_rsp.rem_nz);
        if (last_side.neg) begin
            n_sum = n_base - n_ceil;
        end else begin
            n_sum = n_base + SUM_W'(hue_rsp.quo);
        end
        n_hue = last_side.grey ? '0 : HUE_W'(n_sum);
        n_sat = last_side.black ? '0 : sat_rsp.quo[CHAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= last_side.vmax;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

`ifndef ASSERT_OFF
    a_black_all_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brightness == '0) |-> (o_saturation == '0 && o_hue == '0))
        else $error("black pixel with nonzero saturation or hue");

    a_grey_no_hue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturation == '0) |-> (o_hue == '0))
        else $error("zero saturation with nonzero hue");

    a_sat_below_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation <= o_brightness || o_brightness != '0))
        else $error("saturation out of range");

    a_backpressure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input not stalled while output is held");

    a_hold_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid && i_stall && i_rst_n) |-> (o_valid && $stable(o_hue)))
        else $error("held result changed");
`endif

endmodule

`default_nettype wire

/* rtl/rhsv_prep.sv */
// rhsv_prep: two register stages that find max, min, sector and build the divider requests
// depends on rhsv_pkg
`default_nettype none

module rhsv_prep
    import rhsv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [CHAN_W-1:0] i_red,
    input  wire logic [CHAN_W-1:0] i_green,
    input  wire logic [CHAN_W-1:0] i_blue,
    output logic                   o_valid,
    output t_side                  o_side,
    output t_div_req               o_hue_req,
    output t_div_req               o_sat_req
);

    logic              r_a_valid;
    t_sector           r_a_sector;
    logic [CHAN_W-1:0] r_a_vmax;
    logic [CHAN_W-1:0] r_a_delta;
    logic [CHAN_W:0]   r_a_diff;

    t_sector           n_a_sector;
    logic [CHAN_W-1:0] n_a_vmax;
    logic [CHAN_W-1:0] n_a_vmin;
    logic [CHAN_W:0]   n_a_diff;

    logic              r_b_valid;
    t_side             r_b_side;
    t_div_req          r_b_hue_req;
    t_div_req          r_b_sat_req;

    logic              n_neg;
    logic [CHAN_W:0]   n_abs_wide;
    logic [CHAN_W-1:0] n_abs;

    // stage a: largest channel, ties to red then green, and smallest channel
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_a_sector = SEC_RED;
            n_a_vmax   = i_red;
            n_a_diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green >= i_blue) begin
            n_a_sector = SEC_GREEN;
            n_a_vmax   = i_green;
            n_a_diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_a_sector = SEC_BLUE;
            n_a_vmax   = i_blue;
            n_a_diff   = {1'b0, i_red} - {1'b0, i_green};
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            n_a_vmin = i_red;
        end else if (i_green <= i_blue) begin
            n_a_vmin = i_green;
        end else begin
            n_a_vmin = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sector <= n_a_sector;
            r_a_vmax   <= n_a_vmax;
            r_a_delta  <= n_a_vmax - n_a_vmin;
            r_a_diff   <= n_a_diff;
        end
    end

    // stage b: magnitude of the hue difference and constant scaling
    always_comb begin
        n_neg      = r_a_diff[CHAN_W];
        n_abs_wide = n_neg ? (~r_a_diff + 1'b1) : r_a_diff;
        n_abs      = n_abs_wide[CHAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_side.sector <= r_a_sector;
            r_b_side.neg    <= n_neg;
            r_b_side.grey   <= (r_a_delta == '0);
            r_b_side.black  <= (r_a_vmax == '0);
            r_b_side.vmax   <= r_a_vmax;
            r_b_hue_req.num <= NUM_W'(n_abs) * NUM_W'(HUE_SECTOR);
            r_b_hue_req.den <= r_a_delta;
            r_b_sat_req.num <= NUM_W'(r_a_delta) * NUM_W'(SAT_SCALE);
            r_b_sat_req.den <= r_a_vmax;
        end
    end

    assign o_valid   = r_b_valid;
    assign o_side    = r_b_side;
    assign o_hue_req = r_b_hue_req;
    assign o_sat_req = r_b_sat_req;

endmodule

`default_nettype wire

/* rtl/rhsv_div.sv */
// rhsv_div: pipelined restoring divider, DIV_STEPS quotient bits per register stage
// depends on rhsv_pkg; numerator must be below divisor times 2**QUO_W
`default_nettype none

module rhsv_div
    import rhsv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    // work word: partial remainder on top, numerator bits then quotient bits below
    logic [NUM_W-1:0]  r_work [DIV_STAGES];
    logic [CHAN_W-1:0] r_den  [DIV_STAGES-1];

    logic [NUM_W-1:0]  w_in   [DIV_STAGES];
    logic [CHAN_W-1:0] d_in   [DIV_STAGES];
    logic [NUM_W-1:0]  n_work [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_in[s] = i_req.num;
            assign d_in[s] = i_req.den;
        end else begin : g_next
            assign w_in[s] = r_work[s-1];
            assign d_in[s] = r_den[s-1];
        end

        always_comb begin
            logic [NUM_W-1:0] w;
            logic [CHAN_W:0]  t;
            logic             q;
            w = w_in[s];
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < QUO_W) begin
                    t = {w[NUM_W-1 -: CHAN_W], w[QUO_W-1]};
                    if (t >= {1'b0, d_in[s]}) begin
                        t = t - {1'b0, d_in[s]};
                        q = 1'b1;
                    end else begin
                        q = 1'b0;
                    end
                    w = {t[CHAN_W-1:0], w[QUO_W-2:0], q};
                end
            end
            n_work[s] = w;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_work[s] <= n_work[s];
            end
        end

        if (s < DIV_STAGES - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= d_in[s];
                end
            end
        end
    end

    assign o_rsp.quo    = r_work[DIV_STAGES-1][QUO_W-1:0];
    assign o_rsp.rem_nz = |r_work[DIV_STAGES-1][NUM_W-1:QUO_W];

endmodule

`default_nettype wire

/* tb/hsv_result_checker.sv */
// hsv_result_checker: watches both channels of the rgb to hsv converter
// and predicts each pixel's hue, saturation and value, then checks results in order
// depends on rhsv_pkg
`default_nettype none

module hsv_result_checker
    import rhsv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_px_valid,
    input  wire logic              i_px_stall,
    input  wire logic [CHAN_W-1:0] i_red,
    input  wire logic [CHAN_W-1:0] i_green,
    input  wire logic [CHAN_W-1:0] i_blue,
    input  wire logic              i_hsv_valid,
    input  wire logic              i_hsv_stall,
    input  wire logic [HUE_W-1:0]  i_hue,
    input  wire logic [CHAN_W-1:0] i_saturation,
    input  wire logic [CHAN_W-1:0] i_brightness,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
    } t_hsv;

    t_hsv pending_hsv[$];
    int   err_count = 0;
    int   queued    = 0;

    assign o_errors  = err_count;
    assign o_pending = queued;

    function automatic t_hsv hsv_from_rgb(input logic [CHAN_W-1:0] r8,
                                          input logic [CHAN_W-1:0] g8,
                                          input logic [CHAN_W-1:0] b8);
        int      r, g, b, mx, mn, delta, num, angle;
        t_sector sector;
        t_hsv    px;
        r = int'(r8);
        g = int'(g8);
        b = int'(b8);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        px.val = CHAN_W'(mx);
        px.sat = (mx > 0) ? CHAN_W'((SAT_SCALE * delta) / mx) : '0;
        angle = 0;
        if (delta > 0) begin
            // ties go to red first, then green
            if (r >= g && r >= b) begin
                sector = SEC_RED;
                num = HUE_SECTOR * (g - b);
            end else if (g >= b) begin
                sector = SEC_GREEN;
                num = HUE_SECTOR * (b - r);
            end else begin
                sector = SEC_BLUE;
                num = HUE_SECTOR * (r - g);
            end
            // floor toward minus infinity
            angle = (num >= 0) ? num / delta : -((-num + delta - 1) / delta);
            case (sector)
                SEC_RED: begin
                    if (angle < 0) angle += 6 * HUE_SECTOR;
                end
                SEC_GREEN: angle += 2 * HUE_SECTOR;
                default:   angle += 4 * HUE_SECTOR;
            endcase
        end
        px.hue = HUE_W'(angle);
        return px;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_hsv want;
        if (i_rst_n) begin
            if (i_hsv_valid && !i_hsv_stall) begin
                if (pending_hsv.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, i_hue, i_saturation, i_brightness);
                    err_count++;
                end else begin
                    want = pending_hsv.pop_front();
                    check_field("hue", int'(want.hue), int'(i_hue));
                    check_field("saturation", int'(want.sat), int'(i_saturation));
                    check_field("brightness", int'(want.val), int'(i_brightness));
                end
            end
            if (i_px_valid && !i_px_stall)
                pending_hsv.push_back(hsv_from_rgb(i_red, i_green, i_blue));
            queued = pending_hsv.size();
        end
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: stimulus and verdict for rgb_to_hsv_convert_top
// drives pixels with bursts and gaps, stalls the result side, checks via hsv_result_checker
// depends on rhsv_pkg, rgb_to_hsv_convert_top, hsv_result_checker
`default_nettype none

module tb;
    import rhsv_pkg::*;

    localparam int LONG_HOLD = 80;
    localparam int SETTLE    = 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CHAN_W-1:0] i_red;
    logic [CHAN_W-1:0] i_green;
    logic [CHAN_W-1:0] i_blue;
    logic              o_valid;
    logic              i_stall;
    logic [HUE_W-1:0]  o_hue;
    logic [CHAN_W-1:0] o_saturation;
    logic [CHAN_W-1:0] o_brightness;

    int   hsv_errors;
    int   hsv_pending;
    int   stall_pct = 0;
    logic long_hold_go = 1'b0;
    logic long_hold_done = 1'b0;

    rgb_to_hsv_convert_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    hsv_result_checker hsv_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_px_valid   (i_valid),
        .i_px_stall   (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_hsv_valid  (o_valid),
        .i_hsv_stall  (i_stall),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .i_brightness (o_brightness),
        .o_errors     (hsv_errors),
        .o_pending    (hsv_pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: short random stall runs, plus one long hold when asked
    initial begin : receiver
        int run_left;
        int hold_left;
        run_left = 0;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
                if (hold_left == 0) long_hold_done = 1'b1;
            end else if (long_hold_go && !long_hold_done) begin
                hold_left = LONG_HOLD;
                i_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                run_left = $urandom_range(0, 5);
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // holds the request until it is taken
    task automatic offer_pixel(input logic [CHAN_W-1:0] r,
                               input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (hsv_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic pick_pixel(output logic [CHAN_W-1:0] r,
                              output logic [CHAN_W-1:0] g,
                              output logic [CHAN_W-1:0] b);
        int kind;
        kind = $urandom_range(0, 9);
        r = CHAN_W'($urandom_range(0, 255));
        g = CHAN_W'($urandom_range(0, 255));
        b = CHAN_W'($urandom_range(0, 255));
        case (kind)
            6: begin
                // two channels equal
                case ($urandom_range(0, 2))
                    0:       g = r;
                    1:       b = r;
                    default: b = g;
                endcase
            end
            7: begin
                g = r;
                b = r;
            end
            8: begin
                r = CHAN_W'($urandom_range(0, 3));
                g = CHAN_W'($urandom_range(0, 3));
                b = CHAN_W'($urandom_range(0, 3));
            end
            9: begin
                case ($urandom_range(0, 2))
                    0:       r = 8'hff;
                    1:       g = 8'hff;
                    default: b = 8'hff;
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic stream_pixels(input int count, input int gap_max);
        int                burst;
        logic [CHAN_W-1:0] r, g, b;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 16);
                if (gap_max > 0) idle_cycles($urandom_range(0, gap_max));
            end
            pick_pixel(r, g, b);
            offer_pixel(r, g, b);
            burst--;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // black, white, grey and the pure primaries
        offer_pixel(8'd0, 8'd0, 8'd0);
        offer_pixel(8'd255, 8'd255, 8'd255);
        offer_pixel(8'd128, 8'd128, 8'd128);
        offer_pixel(8'd255, 8'd0, 8'd0);
        offer_pixel(8'd0, 8'd255, 8'd0);
        offer_pixel(8'd0, 8'd0, 8'd255);
        // red largest with negative hue wraps below 360
        offer_pixel(8'd255, 8'd0, 8'd1);
        offer_pixel(8'd200, 8'd10, 8'd199);
        // ties for the largest channel
        offer_pixel(8'd255, 8'd255, 8'd0);
        offer_pixel(8'd255, 8'd0, 8'd255);
        offer_pixel(8'd0, 8'd255, 8'd255);
        offer_pixel(8'd7, 8'd7, 8'd3);
        // smallest nonzero pixels, then other mixed pixels
        offer_pixel(8'd1, 8'd0, 8'd0);
        offer_pixel(8'd0, 8'd1, 8'd0);
        offer_pixel(8'd0, 8'd0, 8'd1);
        offer_pixel(8'd1, 8'd2, 8'd3);
        offer_pixel(8'd254, 8'd1, 8'd255);
        offer_pixel(8'd0, 8'd255, 8'd254);
        offer_pixel(8'd255, 8'd254, 8'd0);
        offer_pixel(8'd170, 8'd85, 8'd85);
        drain();

        stall_pct = 30;
        stream_pixels(300, 3);

        // long result hold while pixels keep coming, so the input backs up
        stall_pct = 20;
        long_hold_go = 1'b1;
        stream_pixels(150, 0);
        wait (long_hold_done);
        drain();
        long_hold_go = 1'b0;

        stall_pct = 0;
        stream_pixels(200, 0);

        stall_pct = 70;
        stream_pixels(200, 6);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (hsv_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
